// ===== src/nfcrfp_pkg.sv =====
// Package for the NFC reader frame parser: field widths, result kinds,
// status codes and frame byte constants. No dependencies.
package nfcrfp_pkg;

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_PREAMBLE = 3'd1,
        ST_APPERR   = 3'd2,
        ST_LCS      = 3'd3,
        ST_TOOLONG  = 3'd4,
        ST_TFI      = 3'd5
    } t_status;

    localparam logic [BYTE_W-1:0] BYTE_ZERO  = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_FF    = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_ERRHI = 8'h01;
    localparam logic [BYTE_W-1:0] BYTE_TFI   = 8'hD5;

    localparam logic [LEN_W-1:0] LEN_HDR_TRIM = 16'd2;
    localparam logic [LEN_W-1:0] TRAIL_BYTES  = 16'd2;
    localparam logic [LEN_W-1:0] ERR_BYTES    = 16'd3;
    localparam logic [LEN_W-1:0] MAX_LEN_RST  = 16'hFFFF;
    localparam logic [BYTE_W:0]  LCS_SUM      = 9'd256;

endpackage

// ===== src/nfc_reader_frame_parser_unit.sv =====
// NFC reader frame parser, top level.
// Depends on nfcrfp_pkg for widths, result kinds and status codes.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one received byte
//   (i_rx_byte). Output channel: o_out_valid / i_out_stall carry one result
//   item: a payload byte, a frame completion with its payload length, or a
//   frame error with a status code (o_last marks completion and error).
//   Configuration: i_cfg_we writes i_cfg_data into the maximum payload
//   length; write it only while no frame is in flight.
//   The result of an accepted byte is registered before it shows at the
//   outputs. Throughput: one byte per cycle while no result is held by
//   i_out_stall, set by the single state update feeding the result register.
//   Bytes that produce no result (header, length, TFI, command and trailer
//   bytes that do not end a frame) are taken without any output.
//   Stall: while a result waits with i_out_stall high, o_in_stall is high;
//   the waiting result holds. As soon as it is taken a new byte enters in
//   the same cycle.
//   Reset (i_rst_n low, synchronous): hunt for a new header, no result
//   pending, maximum payload length back to 65535.
module nfc_reader_frame_parser_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [nfcrfp_pkg::BYTE_W-1:0]       i_rx_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [nfcrfp_pkg::KIND_W-1:0]       o_out_kind,
    output logic [nfcrfp_pkg::BYTE_W-1:0]       o_out_byte,
    output logic [nfcrfp_pkg::STATUS_W-1:0]     o_status,
    output logic [nfcrfp_pkg::LEN_W-1:0]        o_payload_len,
    output logic                                o_last,
    input  logic                                i_cfg_we,
    input  logic [nfcrfp_pkg::LEN_W-1:0]        i_cfg_data
);
    import nfcrfp_pkg::*;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'd0,
        PH_ERRSKIP = 4'd1,
        PH_EXT_M   = 4'd2,
        PH_EXT_L   = 4'd3,
        PH_EXT_CS  = 4'd4,
        PH_TFI     = 4'd5,
        PH_CMD     = 4'd6,
        PH_DATA    = 4'd7,
        PH_TRAIL   = 4'd8
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [2:0]          r_hdr_cnt, n_hdr_cnt;
    logic                r_pre_ok, n_pre_ok;
    logic [BYTE_W-1:0]   r_len_high, n_len_high;
    logic [BYTE_W-1:0]   r_len_low, n_len_low;
    logic [LEN_W-1:0]    r_frame_len, n_frame_len;
    logic [LEN_W-1:0]    r_bytes_left, n_bytes_left;
    logic [LEN_W-1:0]    r_max_len;

    logic                r_out_valid;
    t_kind               r_out_kind;
    logic [BYTE_W-1:0]   r_out_byte;
    t_status             r_status;
    logic [LEN_W-1:0]    r_payload_len;
    logic                r_last;

    logic                res_valid;
    t_kind               res_kind;
    logic [BYTE_W-1:0]   res_byte;
    t_status             res_status;
    logic [LEN_W-1:0]    res_len;

    logic                in_accept;
    logic [LEN_W-1:0]    raw_len;
    logic [LEN_W-1:0]    trim_len;
    logic [LEN_W-1:0]    left_dec;
    logic [BYTE_W:0]     lcs_sum;
    logic [BYTE_W-1:0]   ext_sum;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign raw_len  = (r_phase == PH_EXT_CS) ? {r_len_high, r_len_low}
                                             : {BYTE_ZERO, r_len_high};
    assign trim_len = raw_len - LEN_HDR_TRIM;
    assign left_dec = (r_bytes_left != '0) ? (r_bytes_left - 1'b1) : r_bytes_left;
    assign lcs_sum  = {1'b0, r_len_high} + {1'b0, i_rx_byte};
    assign ext_sum  = r_len_high + r_len_low + i_rx_byte;

    always_comb begin
        n_phase      = r_phase;
        n_hdr_cnt    = r_hdr_cnt;
        n_pre_ok     = r_pre_ok;
        n_len_high   = r_len_high;
        n_len_low    = r_len_low;
        n_frame_len  = r_frame_len;
        n_bytes_left = r_bytes_left;
        res_valid    = 1'b0;
        res_kind     = KIND_ERR;
        res_byte     = BYTE_ZERO;
        res_status   = ST_OK;
        res_len      = '0;
        case (r_phase)
            PH_HEADER: begin
                if (r_hdr_cnt < 3'd3) begin
                    if (i_rx_byte != ((r_hdr_cnt == 3'd2) ? BYTE_FF : BYTE_ZERO)) begin
                        n_pre_ok = 1'b0;
                    end
                    n_hdr_cnt = r_hdr_cnt + 3'd1;
                end else if (r_hdr_cnt == 3'd3) begin
                    n_len_high = i_rx_byte;
                    n_hdr_cnt  = 3'd4;
                end else begin
                    n_len_low = i_rx_byte;
                    n_hdr_cnt = 3'd0;
                    if (!r_pre_ok) begin
                        res_valid  = 1'b1;
                        res_status = ST_PREAMBLE;
                        n_pre_ok   = 1'b1;
                    end else if (r_len_high == BYTE_ERRHI && i_rx_byte == BYTE_FF) begin
                        n_phase      = PH_ERRSKIP;
                        n_bytes_left = ERR_BYTES;
                    end else if (r_len_high == BYTE_FF && i_rx_byte == BYTE_FF) begin
                        n_phase = PH_EXT_M;
                    end else if (lcs_sum != LCS_SUM) begin
                        res_valid  = 1'b1;
                        res_status = ST_LCS;
                    end else if (raw_len < LEN_HDR_TRIM || trim_len > r_max_len) begin
                        res_valid  = 1'b1;
                        res_status = ST_TOOLONG;
                    end else begin
                        n_frame_len = trim_len;
                        n_phase     = PH_TFI;
                    end
                end
            end
            PH_ERRSKIP: begin
                n_bytes_left = left_dec;
                if (left_dec == '0) begin
                    res_valid  = 1'b1;
                    res_status = ST_APPERR;
                    n_phase    = PH_HEADER;
                end
            end
            PH_EXT_M: begin
                n_len_high = i_rx_byte;
                n_phase    = PH_EXT_L;
            end
            PH_EXT_L: begin
                n_len_low = i_rx_byte;
                n_phase   = PH_EXT_CS;
            end
            PH_EXT_CS: begin
                if (ext_sum != BYTE_ZERO) begin
                    res_valid  = 1'b1;
                    res_status = ST_LCS;
                    n_phase    = PH_HEADER;
                end else if (raw_len < LEN_HDR_TRIM || trim_len > r_max_len) begin
                    res_valid  = 1'b1;
                    res_status = ST_TOOLONG;
                    n_phase    = PH_HEADER;
                end else begin
                    n_frame_len = trim_len;
                    n_phase     = PH_TFI;
                end
            end
            PH_TFI: begin
                if (i_rx_byte != BYTE_TFI) begin
                    res_valid  = 1'b1;
                    res_status = ST_TFI;
                    n_phase    = PH_HEADER;
                end else begin
                    n_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                if (r_frame_len != '0) begin
                    n_bytes_left = r_frame_len;
                    n_phase      = PH_DATA;
                end else begin
                    n_bytes_left = TRAIL_BYTES;
                    n_phase      = PH_TRAIL;
                end
            end
            PH_DATA: begin
                n_bytes_left = left_dec;
                if (left_dec == '0) begin
                    n_bytes_left = TRAIL_BYTES;
                    n_phase      = PH_TRAIL;
                end
                res_valid = 1'b1;
                res_kind  = KIND_DATA;
                res_byte  = i_rx_byte;
            end
            PH_TRAIL: begin
                n_bytes_left = left_dec;
                if (left_dec == '0) begin
                    res_valid = 1'b1;
                    res_kind  = KIND_DONE;
                    res_len   = r_frame_len;
                    n_phase   = PH_HEADER;
                    n_hdr_cnt = 3'd0;
                    n_pre_ok  = 1'b1;
                end
            end
            default: begin
                n_phase   = PH_HEADER;
                n_hdr_cnt = 3'd0;
                n_pre_ok  = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_hdr_cnt    <= 3'd0;
            r_pre_ok     <= 1'b1;
            r_len_high   <= BYTE_ZERO;
            r_len_low    <= BYTE_ZERO;
            r_frame_len  <= '0;
            r_bytes_left <= '0;
            r_max_len    <= MAX_LEN_RST;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_len <= i_cfg_data;
            end
            if (in_accept) begin
                r_phase      <= n_phase;
                r_hdr_cnt    <= n_hdr_cnt;
                r_pre_ok     <= n_pre_ok;
                r_len_high   <= n_len_high;
                r_len_low    <= n_len_low;
                r_frame_len  <= n_frame_len;
                r_bytes_left <= n_bytes_left;
            end
            if (in_accept && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_accept && res_valid) begin
            r_out_kind    <= res_kind;
            r_out_byte    <= res_byte;
            r_status      <= res_status;
            r_payload_len <= res_len;
            r_last        <= (res_kind != KIND_DATA);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_kind    = r_out_kind;
    assign o_out_byte    = r_out_byte;
    assign o_status      = r_status;
    assign o_payload_len = r_payload_len;
    assign o_last        = r_last;

    a_data_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_phase == PH_DATA) |=> (o_out_valid && o_out_kind == KIND_DATA))
        else $error("payload byte did not produce a data result");

    a_end_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && res_valid && res_kind != KIND_DATA)
            |=> (r_phase == PH_HEADER && r_hdr_cnt == 3'd0 && r_pre_ok))
        else $error("frame end did not return to header hunt");

    a_data_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA || r_phase == PH_TRAIL || r_phase == PH_ERRSKIP)
            |-> (r_bytes_left != '0))
        else $error("byte counter empty inside a counted phase");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !in_accept)
        else $error("byte accepted while a result is held");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_kind == KIND_DONE) |-> (o_last && o_status == ST_OK))
        else $error("completion result malformed");

endmodule
